// ===== design/assert_macros.svh =====
// Assertion macros shared by the DAC command decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qdac_pkg.sv =====
// Shared types and constants of the quad DAC command decoder.
package qdac_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CODE_BITS    = 12;
    localparam int CH_W         = 2;
    localparam int WORD_W       = 16;

    // Channel register word layout
    localparam int VREF_BIT = 15;
    localparam int PD_HI    = 14;
    localparam int PD_LO    = 13;
    localparam int GAIN_BIT = 12;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    // Bus event codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    // Base of the device address byte
    localparam logic [7:0] ADDR_BASE = 8'hC0;

    // Results caused by one accepted bus word
    typedef struct packed {
        logic                                   has_results;
        logic                                   broadcast;
        logic [CH_W-1:0]                        first_ch;
        logic                                   to_eeprom;
        logic [NUM_CHANNELS-1:0][WORD_W-1:0]    words;
    } qdac_bundle_t;

endpackage

// ===== design/qdac_decoder.sv =====
// Bus word decoder: transaction state, channel registers and EEPROM copies.
`include "assert_macros.svh"

module qdac_decoder
    import qdac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_wdata,
    input  logic         req_accept,
    input  logic [1:0]   req_type,
    input  logic [7:0]   byte_value,
    output qdac_bundle_t bundle
);

    // Command state codes
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_FAST   = 3'd1;
    localparam logic [2:0] CMD_SINGLE = 3'd2;
    localparam logic [2:0] CMD_SEQ    = 3'd3;
    localparam logic [2:0] CMD_PWRDN  = 3'd4;
    localparam logic [2:0] CMD_DONE   = 3'd5;

    // Command byte opcodes
    localparam logic [1:0] OP_FAST   = 2'b00;
    localparam logic [4:0] OP_SINGLE = 5'b01011;
    localparam logic [4:0] OP_SEQ    = 5'b01010;
    localparam logic [2:0] OP_PWRDN  = 3'b101;
    localparam logic [2:0] OP_VREF   = 3'b100;
    localparam logic [2:0] OP_GAIN   = 3'b110;

    logic [2:0]      addr_sel_reg;
    logic            phase_reg, phase_next;
    logic [2:0]      cmd_reg, cmd_next;
    logic            pos_reg, pos_next;
    logic [7:0]      held_reg, held_next;
    logic [CH_W-1:0] tgt_reg, tgt_next;
    logic [NUM_CHANNELS-1:0][WORD_W-1:0] chan_reg, chan_next;
    logic [NUM_CHANNELS-1:0][WORD_W-1:0] eep_reg, eep_next;

    logic [7:0]        addr_byte;
    logic [WORD_W-1:0] pair_word;
    logic [7:0]        pd_all;
    logic              eep_write;

    assign addr_byte = ADDR_BASE + {4'b0, addr_sel_reg, 1'b0};
    assign pair_word = {held_reg, byte_value};
    assign pd_all    = {held_reg[3:0], byte_value[7:4]};
    assign eep_write = (req_type == REQ_DATA) && phase_reg && pos_reg
                       && (cmd_reg == CMD_SINGLE || cmd_reg == CMD_SEQ);

    // Next state and result bundle for the presented word
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        tgt_next   = tgt_reg;
        chan_next  = chan_reg;
        eep_next   = eep_reg;
        bundle.has_results = 1'b0;
        bundle.broadcast   = 1'b0;
        bundle.first_ch    = tgt_reg;
        bundle.to_eeprom   = 1'b0;

        case (req_type)
            REQ_START:
            begin
                phase_next = (byte_value == addr_byte);
                cmd_next   = CMD_NONE;
                pos_next   = 1'b0;
            end
            REQ_STOP:
            begin
                phase_next = 1'b0;
                cmd_next   = CMD_NONE;
                pos_next   = 1'b0;
            end
            REQ_DATA:
            begin
                if (phase_reg)
                begin
                    case (cmd_reg)
                        CMD_NONE:
                        begin
                            pos_next = 1'b0;
                            if (byte_value[7:6] == OP_FAST)
                            begin
                                cmd_next  = CMD_FAST;
                                held_next = byte_value;
                                tgt_next  = '0;
                                pos_next  = 1'b1;
                            end
                            else if (byte_value[7:3] == OP_SINGLE)
                            begin
                                cmd_next = CMD_SINGLE;
                                tgt_next = byte_value[2:1];
                            end
                            else if (byte_value[7:3] == OP_SEQ)
                            begin
                                cmd_next = CMD_SEQ;
                                tgt_next = byte_value[2:1];
                            end
                            else if (byte_value[7:5] == OP_PWRDN)
                            begin
                                cmd_next  = CMD_PWRDN;
                                held_next = byte_value;
                            end
                            else
                            begin
                                cmd_next = CMD_DONE;
                                // broadcast vref or gain select, channel A in bit 3
                                if (byte_value[7:5] == OP_VREF || byte_value[7:5] == OP_GAIN)
                                begin
                                    for (int i = 0; i < NUM_CHANNELS; i++)
                                    begin
                                        if (byte_value[7:5] == OP_VREF)
                                            chan_next[i][VREF_BIT] = byte_value[3-i];
                                        else
                                            chan_next[i][GAIN_BIT] = byte_value[3-i];
                                    end
                                    bundle.has_results = 1'b1;
                                    bundle.broadcast   = 1'b1;
                                end
                            end
                        end
                        CMD_FAST:
                        begin
                            if (!pos_reg)
                            begin
                                held_next = byte_value;
                                pos_next  = 1'b1;
                            end
                            else
                            begin
                                // vref and gain are kept
                                chan_next[tgt_reg][PD_HI:PD_LO] = held_reg[5:4];
                                chan_next[tgt_reg][CODE_BITS-1:0] = pair_word[CODE_BITS-1:0];
                                tgt_next = tgt_reg + 1'b1;
                                pos_next = 1'b0;
                                bundle.has_results = 1'b1;
                            end
                        end
                        CMD_SINGLE, CMD_SEQ:
                        begin
                            if (!pos_reg)
                            begin
                                held_next = byte_value;
                                pos_next  = 1'b1;
                            end
                            else
                            begin
                                chan_next[tgt_reg] = pair_word;
                                eep_next[tgt_reg]  = pair_word;
                                pos_next = 1'b0;
                                if (cmd_reg == CMD_SINGLE || tgt_reg == LAST_CH)
                                    cmd_next = CMD_DONE;
                                else
                                    tgt_next = tgt_reg + 1'b1;
                                bundle.has_results = 1'b1;
                                bundle.to_eeprom   = 1'b1;
                            end
                        end
                        CMD_PWRDN:
                        begin
                            for (int i = 0; i < NUM_CHANNELS; i++)
                                chan_next[i][PD_HI:PD_LO] = pd_all[7-2*i -: 2];
                            cmd_next = CMD_DONE;
                            bundle.has_results = 1'b1;
                            bundle.broadcast   = 1'b1;
                        end
                        default:
                        begin
                            cmd_next = cmd_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (bundle.broadcast)
            bundle.first_ch = '0;
        bundle.words = chan_next;
    end

    // Address select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_sel_reg <= '0;
        else if (cfg_we)
            addr_sel_reg <= cfg_wdata;
    end

    // Transaction state and channel storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            cmd_reg   <= CMD_NONE;
            pos_reg   <= 1'b0;
            held_reg  <= '0;
            tgt_reg   <= '0;
            chan_reg  <= '0;
            eep_reg   <= '0;
        end
        else if (req_accept)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            tgt_reg   <= tgt_next;
            chan_reg  <= chan_next;
            eep_reg   <= eep_next;
        end
    end

    `ASSERT_NEXT(a_eep_match, clk, rst_n, req_accept && eep_write,
        eep_reg[$past(tgt_reg)] == chan_reg[$past(tgt_reg)],
        "EEPROM copy differs from channel register after write")

    `ASSERT_NEXT(a_start_clears, clk, rst_n, req_accept && req_type == REQ_START,
        cmd_reg == CMD_NONE && !pos_reg,
        "start did not clear the command state")

endmodule

// ===== design/qdac_emitter.sv =====
// Result sequencer: holds one word's results and shows them one per cycle while the receiver does not stall.
`include "assert_macros.svh"

module qdac_emitter
    import qdac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  qdac_bundle_t         bundle,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [CH_W-1:0]      channel,
    output logic [CODE_BITS-1:0] code,
    output logic                 vref_internal,
    output logic                 gain_double,
    output logic [1:0]           power_down,
    output logic                 to_eeprom,
    output logic                 last
);

    logic                                bv_reg;
    logic [CH_W-1:0]                     bch_reg;
    logic [CH_W-1:0]                     blast_reg;
    logic                                beep_reg;
    logic [NUM_CHANNELS-1:0][WORD_W-1:0] bwords_reg;

    logic              ov_reg;
    logic [CH_W-1:0]   och_reg;
    logic [WORD_W-1:0] oword_reg;
    logic              oeep_reg;
    logic              olast_reg;

    logic take;
    logic take_last;

    assign take      = bv_reg && (!ov_reg || !res_stall);
    assign take_last = take && (bch_reg == blast_reg);
    assign busy      = bv_reg && !take_last;

    // Pending result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg  <= 1'b0;
            bch_reg <= '0;
        end
        else if (load)
        begin
            bv_reg  <= bundle.has_results;
            bch_reg <= bundle.first_ch;
        end
        else if (take)
        begin
            if (take_last)
                bv_reg <= 1'b0;
            else
                bch_reg <= bch_reg + 1'b1;
        end
    end

    // Pending result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blast_reg  <= bundle.broadcast ? LAST_CH : bundle.first_ch;
            beep_reg   <= bundle.to_eeprom;
            bwords_reg <= bundle.words;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (take)
            ov_reg <= 1'b1;
        else if (!res_stall)
            ov_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            och_reg   <= bch_reg;
            oword_reg <= bwords_reg[bch_reg];
            oeep_reg  <= beep_reg;
            olast_reg <= take_last;
        end
    end

    assign res_valid     = ov_reg;
    assign channel       = och_reg;
    assign code          = oword_reg[CODE_BITS-1:0];
    assign vref_internal = oword_reg[VREF_BIT];
    assign gain_double   = oword_reg[GAIN_BIT];
    assign power_down    = oword_reg[PD_HI:PD_LO];
    assign to_eeprom     = oeep_reg;
    assign last          = olast_reg;

    `ASSERT_NEXT(a_pending_moves, clk, rst_n, bv_reg && !ov_reg, ov_reg,
        "pending result not moved into empty output register")

    `ASSERT_NEXT(a_last_marked, clk, rst_n, take_last, ov_reg && olast_reg,
        "final result of a word not marked last")

    `ASSERT_IMPLY(a_no_load_busy, clk, rst_n, load, !bv_reg || take_last,
        "word accepted over unfinished results")

endmodule

// ===== design/quad_dac_command_decoder_top.sv =====
// Top level of the quad DAC command decoder.
// Results of an accepted word wait in the sequencer's pending register, then move into the output register.
// Throughput: one bus word per cycle while the output is not stalled; a broadcast select stalls the input
// while the sequencer moves its four results, one per cycle when not stalled, into the output register.
// Reset (rst_n low, asynchronous) idles the bus state, clears address select and
// zeroes all channel registers and EEPROM copies.
module quad_dac_command_decoder_top
    import qdac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           req_type,
    input  logic [7:0]           byte_value,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [CH_W-1:0]      channel,
    output logic [CODE_BITS-1:0] code,
    output logic                 vref_internal,
    output logic                 gain_double,
    output logic [1:0]           power_down,
    output logic                 to_eeprom,
    output logic                 last
);

    qdac_bundle_t bundle;
    logic         busy;
    logic         req_accept;

    assign req_stall  = busy;
    assign req_accept = req_valid && !busy;

    // Word decode and channel storage
    qdac_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_accept (req_accept),
        .req_type   (req_type),
        .byte_value (byte_value),
        .bundle     (bundle)
    );

    // Result sequencing
    qdac_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (req_accept),
        .bundle        (bundle),
        .busy          (busy),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .channel       (channel),
        .code          (code),
        .vref_internal (vref_internal),
        .gain_double   (gain_double),
        .power_down    (power_down),
        .to_eeprom     (to_eeprom),
        .last          (last)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the quad DAC command decoder: bus words in, channel updates out.
`timescale 1ns / 1ps

module tb;
    import qdac_pkg::*;

    // Bus word code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Command byte patterns and the masks that pick them out
    localparam logic [7:0] FAST_MASK  = 8'hC0;
    localparam logic [7:0] FAST_PAT   = 8'h00;
    localparam logic [7:0] WRITE_MASK = 8'hF8;
    localparam logic [7:0] SEQ_PAT    = 8'h50;
    localparam logic [7:0] SINGLE_PAT = 8'h58;
    localparam logic [7:0] SEL_MASK   = 8'hE0;
    localparam logic [7:0] VREF_PAT   = 8'h80;
    localparam logic [7:0] PD_PAT     = 8'hA0;
    localparam logic [7:0] GAIN_PAT   = 8'hC0;

    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 600;
    localparam int MAX_PRINTS  = 40;

    typedef enum logic [2:0] {OP_WAIT, OP_FAST, OP_SINGLE, OP_SEQ, OP_PD_SEL, OP_IGNORE} op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
    } bus_word_t;

    typedef struct packed {
        logic [CH_W-1:0]      ch;
        logic [CODE_BITS-1:0] code;
        logic                 vref;
        logic                 gain;
        logic [1:0]           pd;
        logic                 eep;
        logic                 last;
    } dac_update_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_wdata = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [1:0]           req_type = REQ_STOP;
    logic [7:0]           byte_value = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [CH_W-1:0]      channel;
    logic [CODE_BITS-1:0] code;
    logic                 vref_internal;
    logic                 gain_double;
    logic [1:0]           power_down;
    logic                 to_eeprom;
    logic                 last;

    quad_dac_command_decoder_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .byte_value(byte_value), .res_valid(res_valid), .res_stall(res_stall),
        .channel(channel), .code(code), .vref_internal(vref_internal),
        .gain_double(gain_double), .power_down(power_down), .to_eeprom(to_eeprom),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    bus_word_t   pending_words[$];
    dac_update_t updates_due[$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          updates_seen = 0;
    int          errors = 0;
    int          stuck = 0;
    int          hold_left = 0;
    bit          word_taken = 1'b0;
    bit          idle_on = 1'b1;
    bit          hold_go = 1'b0;
    logic [2:0]  sel_now = '0;

    // Decoder model state
    logic [2:0]  addr_id = '0;
    bit          addressed = 1'b0;
    op_t         op = OP_WAIT;
    bit          half_pair = 1'b0;
    logic [7:0]  held = '0;
    logic [1:0]  tgt = '0;
    logic [WORD_W-1:0] dac_reg[NUM_CHANNELS] = '{default: '0};

    task automatic report(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Queue the update that channel c now shows
    task automatic post_update(input logic [1:0] c, input logic eep, input logic fin);
        dac_update_t u;
        logic [WORD_W-1:0] w;
        w = dac_reg[c];
        u.ch   = c;
        u.code = w[CODE_BITS-1:0];
        u.vref = w[VREF_BIT];
        u.gain = w[GAIN_BIT];
        u.pd   = w[PD_HI:PD_LO];
        u.eep  = eep;
        u.last = fin;
        updates_due.push_back(u);
    endtask

    task automatic post_all();
        for (int i = 0; i < NUM_CHANNELS; i++)
            post_update(2'(i), 1'b0, i == NUM_CHANNELS - 1);
    endtask

    // Broadcast one nibble bit per channel, channel 0 from the top bit
    task automatic set_bit_all(input logic [3:0] nib, input int pos);
        for (int i = 0; i < NUM_CHANNELS; i++)
            dac_reg[i][pos] = nib[3 - i];
    endtask

    // Predict the channel updates caused by one accepted bus word
    task automatic apply_bus_word(input logic [1:0] kind, input logic [7:0] b);
        logic [1:0] c;
        c = tgt;
        if (kind == REQ_START)
        begin
            addressed = (b == ADDR_BASE + {4'b0, addr_id, 1'b0});
            op = OP_WAIT;
            half_pair = 1'b0;
        end
        else if (kind == REQ_STOP)
        begin
            addressed = 1'b0;
            op = OP_WAIT;
            half_pair = 1'b0;
        end
        else if (kind == REQ_DATA && addressed)
        begin
            case (op)
                OP_WAIT:
                begin
                    half_pair = 1'b0;
                    if ((b & FAST_MASK) == FAST_PAT)
                    begin
                        // command byte doubles as the high byte of the first pair
                        op = OP_FAST;
                        held = b;
                        tgt = '0;
                        half_pair = 1'b1;
                    end
                    else if ((b & WRITE_MASK) == SINGLE_PAT)
                    begin
                        op = OP_SINGLE;
                        tgt = b[2:1];
                    end
                    else if ((b & WRITE_MASK) == SEQ_PAT)
                    begin
                        op = OP_SEQ;
                        tgt = b[2:1];
                    end
                    else if ((b & SEL_MASK) == PD_PAT)
                    begin
                        op = OP_PD_SEL;
                        held = b;
                    end
                    else
                    begin
                        op = OP_IGNORE;
                        if ((b & SEL_MASK) == VREF_PAT)
                        begin
                            set_bit_all(b[3:0], VREF_BIT);
                            post_all();
                        end
                        else if ((b & SEL_MASK) == GAIN_PAT)
                        begin
                            set_bit_all(b[3:0], GAIN_BIT);
                            post_all();
                        end
                    end
                end
                OP_FAST:
                begin
                    if (!half_pair)
                    begin
                        held = b;
                        half_pair = 1'b1;
                    end
                    else
                    begin
                        // vref and gain are kept on a fast write
                        dac_reg[c] = {dac_reg[c][VREF_BIT], held[5:4], dac_reg[c][GAIN_BIT],
                                      held[3:0], b};
                        tgt = c + 2'd1;
                        half_pair = 1'b0;
                        post_update(c, 1'b0, 1'b1);
                    end
                end
                OP_SINGLE, OP_SEQ:
                begin
                    if (!half_pair)
                    begin
                        held = b;
                        half_pair = 1'b1;
                    end
                    else
                    begin
                        dac_reg[c] = {held, b};
                        half_pair = 1'b0;
                        if (op == OP_SINGLE || c == LAST_CH)
                            op = OP_IGNORE;
                        else
                            tgt = c + 2'd1;
                        post_update(c, 1'b1, 1'b1);
                    end
                end
                OP_PD_SEL:
                begin
                    dac_reg[0][PD_HI:PD_LO] = held[3:2];
                    dac_reg[1][PD_HI:PD_LO] = held[1:0];
                    dac_reg[2][PD_HI:PD_LO] = b[7:6];
                    dac_reg[3][PD_HI:PD_LO] = b[5:4];
                    op = OP_IGNORE;
                    post_all();
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_update();
        dac_update_t want;
        updates_seen++;
        if (updates_due.size() == 0)
            report("unexpected update on channel", channel, -1);
        else
        begin
            want = updates_due.pop_front();
            if (channel !== want.ch)        report("channel", channel, want.ch);
            if (code !== want.code)         report("code", code, want.code);
            if (vref_internal !== want.vref) report("vref_internal", vref_internal, want.vref);
            if (gain_double !== want.gain)  report("gain_double", gain_double, want.gain);
            if (power_down !== want.pd)     report("power_down", power_down, want.pd);
            if (to_eeprom !== want.eep)     report("to_eeprom", to_eeprom, want.eep);
            if (last !== want.last)         report("last", last, want.last);
        end
    endtask

    // Monitor: sample at the rising edge, predict, check, watch for a hang
    always @(posedge clk)
    begin
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                addr_id = cfg_wdata;
            if (req_valid && !req_stall)
            begin
                word_taken = 1'b1;
                words_taken++;
                apply_bus_word(req_type, byte_value);
            end
            if (res_valid && !res_stall)
                check_update();
            if (word_taken || (res_valid && !res_stall) || cfg_we)
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
                $display("quad_dac_command_decoder_top: mismatch");
                $finish;
            end
        end
    end

    // Driver: present the next bus word at the falling edge
    always @(negedge clk)
    begin
        bus_word_t nxt;
        if (rst_n && (!req_valid || word_taken))
        begin
            if (pending_words.size() != 0 && !(idle_on && $urandom_range(99) < 17))
            begin
                nxt = pending_words.pop_front();
                req_valid  <= 1'b1;
                req_type   <= nxt.kind;
                byte_value <= nxt.val;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_go = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= idle_on && ($urandom_range(99) < 17);
    end

    function automatic logic [7:0] my_addr();
        return ADDR_BASE + {4'b0, sel_now, 1'b0};
    endfunction

    task automatic add(input logic [1:0] kind, input logic [7:0] b);
        bus_word_t w;
        w.kind = kind;
        w.val  = b;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic write_sel(input logic [2:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sel_now = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender pause: everything taken, every update back, then settle
    task automatic wait_quiet();
        while (words_taken != words_queued || updates_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One random transaction; returns the number of words it queued
    task automatic gen_txn(input bit bcast_only, output int n_words);
        int r, n, kind_sel;
        logic [7:0] b;
        n_words = 0;
        r = $urandom_range(99);
        if (!bcast_only && r < 8)
        begin
            // line noise, every event code including the unused one
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add(2'($urandom_range(3)), 8'($urandom));
            n_words = n;
            return;
        end
        r = $urandom_range(99);
        if (bcast_only || r >= 10)
            b = my_addr();
        else if (r < 6)
            b = 8'($urandom);
        else
            b = my_addr() | 8'h01;
        add(REQ_START, b);
        n_words = 1;
        kind_sel = bcast_only ? 3 + $urandom_range(2) : $urandom_range(7);
        b = 8'($urandom);
        n = 0;
        case (kind_sel)
            0, 7:
            begin
                add(REQ_DATA, FAST_PAT | {2'b00, b[5:0]});
                n = $urandom_range(1, 9);
            end
            1:
            begin
                add(REQ_DATA, SINGLE_PAT | {5'b0, b[2:0]});
                n = $urandom_range(1, 4);
            end
            2:
            begin
                add(REQ_DATA, SEQ_PAT | {5'b0, b[2:0]});
                n = $urandom_range(1, 10);
            end
            3:
            begin
                add(REQ_DATA, VREF_PAT | {3'b0, b[4:0]});
                n = $urandom_range(0, 1);
            end
            4:
            begin
                add(REQ_DATA, GAIN_PAT | {3'b0, b[4:0]});
                n = $urandom_range(0, 1);
            end
            5:
            begin
                add(REQ_DATA, PD_PAT | {3'b0, b[4:0]});
                n = $urandom_range(0, 2);
            end
            default:
            begin
                // multi-write, other 01xxxxxx, and 111xxxxx are unknown
                r = $urandom_range(2);
                if (r == 0)
                    add(REQ_DATA, {5'b01000, b[2:0]});
                else if (r == 1)
                    add(REQ_DATA, {3'b011, b[4:0]});
                else
                    add(REQ_DATA, {3'b111, b[4:0]});
                n = $urandom_range(0, 3);
            end
        endcase
        for (int i = 0; i < n; i++)
            add(REQ_DATA, 8'($urandom));
        n_words += n + 1;
        // most transactions close with a stop, the rest run into a repeated start
        if ($urandom_range(99) < 85)
        begin
            add(REQ_STOP, 8'($urandom));
            n_words++;
        end
    endtask

    task automatic random_phase(input int target, input bit bcast_only);
        int got, n;
        got = 0;
        while (got < target)
        begin
            gen_txn(bcast_only, n);
            got += n;
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command, the open cases
        write_sel(3'd0);
        add(REQ_START, my_addr());
        add(REQ_DATA, FAST_PAT | 8'h3F);
        add(REQ_DATA, 8'hFF);
        add(REQ_DATA, 8'h00);
        add(REQ_DATA, 8'h00);
        add(REQ_STOP, 8'hFF);
        add(REQ_START, my_addr());
        add(REQ_DATA, SINGLE_PAT | 8'h06);
        add(REQ_DATA, 8'hFF);
        add(REQ_DATA, 8'hFF);
        add(REQ_DATA, 8'h12);
        add(REQ_STOP, 8'h00);
        add(REQ_START, my_addr());
        add(REQ_DATA, SEQ_PAT | 8'h04);
        add(REQ_DATA, 8'h80);
        add(REQ_DATA, 8'h00);
        add(REQ_DATA, 8'h7F);
        add(REQ_DATA, 8'hFF);
        add(REQ_DATA, 8'h33);
        add(REQ_STOP, 8'h00);
        add(REQ_START, my_addr());
        add(REQ_DATA, VREF_PAT | 8'h1F);
        add(REQ_START, my_addr());
        add(REQ_DATA, GAIN_PAT | 8'h0A);
        add(REQ_START, my_addr());
        add(REQ_DATA, PD_PAT | 8'h16);
        add(REQ_DATA, 8'h9F);
        add(REQ_STOP, 8'h00);
        // wrong address, unused event code, data while idle
        add(REQ_START, my_addr() ^ 8'h02);
        add(REQ_DATA, VREF_PAT | 8'h0F);
        add(REQ_UNUSED, 8'hFF);
        add(REQ_STOP, 8'h00);
        add(REQ_DATA, GAIN_PAT | 8'h05);
        wait_quiet();

        write_sel(3'd7);
        random_phase(35, 1'b0);
        wait_quiet();

        // stretch with no idling on either side
        idle_on = 1'b0;
        write_sel(3'd3);
        random_phase(30, 1'b0);
        wait_quiet();

        // long receiver hold-off while broadcasts keep coming
        idle_on = 1'b1;
        write_sel(3'($urandom));
        hold_go = 1'b1;
        random_phase(25, 1'b1);
        wait_quiet();

        write_sel(3'd5);
        random_phase(45, 1'b0);
        wait_quiet();

        $display("run covered %0d bus words and %0d channel updates", words_taken, updates_seen);
        $display("address ids 0, 7, 3, 5 and one random; errors found: %0d", errors);
        if (errors == 0)
            $display("quad_dac_command_decoder_top: match");
        else
            $display("quad_dac_command_decoder_top: mismatch");
        $finish;
    end

endmodule
